### src/lnb_pkg.sv
// ---------------------------------------------------------------------------
// lnb_pkg
// Shared types and constants for the leaky integrate-and-fire neuron bank.
// ---------------------------------------------------------------------------
`default_nettype none

package lnb_pkg;

   // bank size and field widths
   localparam int CHANNELS  = 64;
   localparam int ADDR_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CH_W      = 6;
   localparam int CUR_W     = 16;
   localparam int POT_W     = 24;
   localparam int SINCE_W   = 10;
   localparam int DECAY_W   = 16;
   localparam int GAIN_W    = 24;

   // stream and control port widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // arithmetic widths
   localparam int GP_W    = GAIN_W + 1 + CUR_W;     // gain * current
   localparam int DP_W    = DECAY_W + 1 + POT_W;    // decay * membrane
   localparam int FRAC_SH = 16;
   localparam int ACC_W   = 43;
   localparam int Q_W     = ACC_W - FRAC_SH;
   localparam int ROUND_HALF = 32768;

   localparam logic [SINCE_W-1:0]      SINCE_MAX = 10'd1023;
   localparam logic signed [Q_W-1:0]   POT_MAX_Q = 27'sd8388607;
   localparam logic signed [Q_W-1:0]   POT_MIN_Q = -27'sd8388608;
   localparam logic signed [POT_W-1:0] POT_MAX   = 24'sh7FFFFF;
   localparam logic signed [POT_W-1:0] POT_MIN   = 24'sh800000;

   // register reset values
   localparam logic [DECAY_W-1:0]      DECAY_RST       = 16'd64083;
   localparam logic [GAIN_W-1:0]       GAIN_RST        = 24'd435944;
   localparam logic signed [POT_W-1:0] REST_TERM_RST   = -24'sd398;
   localparam logic signed [POT_W-1:0] THRESHOLD_RST   = -24'sd12800;
   localparam logic signed [POT_W-1:0] SPIKE_LEVEL_RST = 24'sd8960;
   localparam logic signed [POT_W-1:0] REST_LEVEL_RST  = -24'sd17920;
   localparam logic [SINCE_W-1:0]      REFRACT_RST     = 10'd132;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DECAY       = 3'd0,
      CSR_GAIN        = 3'd1,
      CSR_REST_TERM   = 3'd2,
      CSR_THRESHOLD   = 3'd3,
      CSR_SPIKE_LEVEL = 3'd4,
      CSR_REST_LEVEL  = 3'd5,
      CSR_REFRACT     = 3'd6
   } csr_idx_type;

   // per-channel neuron state as stored in the state RAM
   typedef struct packed {
      logic [SINCE_W-1:0]      since;
      logic signed [POT_W-1:0] mem;
   } nrn_state_type;

   localparam int STATE_W = SINCE_W + POT_W;
   localparam nrn_state_type STATE_RST = '{since: SINCE_MAX, mem: REST_LEVEL_RST};

   // one state write, kept for bypass to younger items
   typedef struct packed {
      logic          vld;
      logic [CH_W-1:0] ch;
      nrn_state_type st;
   } wr_rec_type;

endpackage

`default_nettype wire

### src/lnb_ram.sv
// ---------------------------------------------------------------------------
// lnb_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ---------------------------------------------------------------------------
`default_nettype none

module lnb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

### src/lif_neuron_bank_top.sv
// ---------------------------------------------------------------------------
// lif_neuron_bank_top
// Pipeline stages from req beat to rsp beat (A: state RAM read and
//   gain*current, B: decay*membrane, sum, round, saturate, fire, C: rsp reg).
// Throughput: one beat per cycle unless the result reg stalls, any channel order;
//   the per-channel recurrence closes in stage B, with bypass from the two latest writes.
// Reset: synchronous; registers take their defaults, all channels read as
//   rest level and not refractory at once (per-channel valid flops).
// ---------------------------------------------------------------------------
`default_nettype none

module lif_neuron_bank_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request stream
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [lnb_pkg::REQ_DATA_W-1:0]   req_tdata,  // [5:0] channel, [21:6] current
   // result stream
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [lnb_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [5:0] out_channel,
                                                             // [29:6] potential, [30] spike
   // register write port
   input  wire logic                             csr_we,
   input  wire logic [lnb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lnb_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // ---------------- configuration registers ----------------
   logic [lnb_pkg::DECAY_W-1:0]      decay_ff;
   logic [lnb_pkg::GAIN_W-1:0]       gain_ff;
   logic signed [lnb_pkg::POT_W-1:0] rest_term_ff;
   logic signed [lnb_pkg::POT_W-1:0] threshold_ff;
   logic signed [lnb_pkg::POT_W-1:0] spike_level_ff;
   logic signed [lnb_pkg::POT_W-1:0] rest_level_ff;
   logic [lnb_pkg::SINCE_W-1:0]      refract_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff       <= lnb_pkg::DECAY_RST;
         gain_ff        <= lnb_pkg::GAIN_RST;
         rest_term_ff   <= lnb_pkg::REST_TERM_RST;
         threshold_ff   <= lnb_pkg::THRESHOLD_RST;
         spike_level_ff <= lnb_pkg::SPIKE_LEVEL_RST;
         rest_level_ff  <= lnb_pkg::REST_LEVEL_RST;
         refract_ff     <= lnb_pkg::REFRACT_RST;
      end else if (csr_we) begin
         case (lnb_pkg::csr_idx_type'(csr_index))
            lnb_pkg::CSR_DECAY:       decay_ff       <= csr_wdata[lnb_pkg::DECAY_W-1:0];
            lnb_pkg::CSR_GAIN:        gain_ff        <= csr_wdata;
            lnb_pkg::CSR_REST_TERM:   rest_term_ff   <= $signed(csr_wdata);
            lnb_pkg::CSR_THRESHOLD:   threshold_ff   <= $signed(csr_wdata);
            lnb_pkg::CSR_SPIKE_LEVEL: spike_level_ff <= $signed(csr_wdata);
            lnb_pkg::CSR_REST_LEVEL:  rest_level_ff  <= $signed(csr_wdata);
            lnb_pkg::CSR_REFRACT:     refract_ff     <= csr_wdata[lnb_pkg::SINCE_W-1:0];
            default: ;  // index past the register list: dropped
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   // Whole pipe moves together; it stalls only when the result reg is full
   // and not being taken.
   logic rsp_valid_ff;
   logic adv;
   logic req_acc;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = !reset && adv;
   assign req_acc    = req_tvalid && req_tready;

   logic [lnb_pkg::CH_W-1:0]           req_ch;
   logic signed [lnb_pkg::CUR_W-1:0]   req_cur;

   assign req_ch  = req_tdata[lnb_pkg::CH_W-1:0];
   assign req_cur = $signed(req_tdata[lnb_pkg::CH_W +: lnb_pkg::CUR_W]);

   // ---------------- state RAM and valid flags ----------------
   lnb_pkg::wr_rec_type wr_in;      // write issued at this edge
   lnb_pkg::wr_rec_type wr1_ff;     // write of the previous advance
   lnb_pkg::wr_rec_type wr2_ff;     // write of the one before
   logic [lnb_pkg::STATE_W-1:0] ram_rdata;
   logic [lnb_pkg::CHANNELS-1:0] chan_vld_ff;

   lnb_ram #(
      .WIDTH (lnb_pkg::STATE_W),
      .DEPTH (lnb_pkg::CHANNELS)
   ) u_state_ram (
      .clock (clock),
      .we    (adv && wr_in.vld),
      .waddr (lnb_pkg::ADDR_W'(wr_in.ch)),
      .wdata (wr_in.st),
      .re    (adv),
      .raddr (lnb_pkg::ADDR_W'(req_ch)),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_vld_ff <= '0;
      end else if (adv && wr_in.vld) begin
         chan_vld_ff[lnb_pkg::ADDR_W'(wr_in.ch)] <= 1'b1;
      end
   end

   // ---------------- stage A: RAM read returns, gain*current ----------------
   logic                               a_valid_ff;
   logic [lnb_pkg::CH_W-1:0]           a_ch_ff;
   logic signed [lnb_pkg::CUR_W-1:0]   a_cur_ff;
   logic                               a_chv_ff;   // channel written since reset
   logic signed [lnb_pkg::GP_W-1:0]    a_gp;

   assign a_gp = $signed({1'b0, gain_ff}) * a_cur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ch_ff  <= req_ch;
         a_cur_ff <= req_cur;
         a_chv_ff <= chan_vld_ff[lnb_pkg::ADDR_W'(req_ch)];
      end
   end

   // ---------------- stage B: neuron update ----------------
   logic                               b_valid_ff;
   logic [lnb_pkg::CH_W-1:0]           b_ch_ff;
   logic signed [lnb_pkg::GP_W-1:0]    b_gp_ff;
   logic                               b_chv_ff;
   lnb_pkg::nrn_state_type             b_ram_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_ch_ff  <= a_ch_ff;
         b_gp_ff  <= a_gp;
         b_chv_ff <= a_chv_ff;
         b_ram_ff <= ram_rdata;
      end
   end

   // The RAM read of this item was issued, read-first, as it entered stage A,
   // so the writes of that advance and of the later one are not in it yet.
   lnb_pkg::nrn_state_type prev;

   always_comb begin
      if (wr1_ff.vld && (wr1_ff.ch == b_ch_ff)) begin
         prev = wr1_ff.st;
      end else if (wr2_ff.vld && (wr2_ff.ch == b_ch_ff)) begin
         prev = wr2_ff.st;
      end else if (b_chv_ff) begin
         prev = b_ram_ff;
      end else begin
         prev = lnb_pkg::STATE_RST;
      end
   end

   logic                               ch_ok;
   logic [lnb_pkg::SINCE_W-1:0]        d_sat;
   logic                               refr;
   logic signed [lnb_pkg::DP_W-1:0]    dp;
   logic signed [lnb_pkg::ACC_W-1:0]   acc;
   logic signed [lnb_pkg::ACC_W-1:0]   rnd;
   logic signed [lnb_pkg::Q_W-1:0]     q;
   logic signed [lnb_pkg::POT_W-1:0]   pot_sat;
   logic                               fire;
   logic signed [lnb_pkg::POT_W-1:0]   rsp_pot_in;
   logic                               rsp_spike_in;

   assign ch_ok = (32'(b_ch_ff) < lnb_pkg::CHANNELS);
   assign d_sat = (prev.since == lnb_pkg::SINCE_MAX) ? lnb_pkg::SINCE_MAX
                                                     : prev.since + 10'd1;
   assign refr  = (d_sat < refract_ff);

   assign dp  = $signed({1'b0, decay_ff}) * prev.mem;
   // exact sum with 24 fraction bits, then round half up to 8
   assign acc = (lnb_pkg::ACC_W'(rest_term_ff) <<< lnb_pkg::FRAC_SH)
              + lnb_pkg::ACC_W'(dp) + lnb_pkg::ACC_W'(b_gp_ff);
   assign rnd = acc + lnb_pkg::ACC_W'(lnb_pkg::ROUND_HALF);
   assign q   = $signed(rnd[lnb_pkg::ACC_W-1:lnb_pkg::FRAC_SH]);

   always_comb begin
      if (q > lnb_pkg::POT_MAX_Q) begin
         pot_sat = lnb_pkg::POT_MAX;
      end else if (q < lnb_pkg::POT_MIN_Q) begin
         pot_sat = lnb_pkg::POT_MIN;
      end else begin
         pot_sat = q[lnb_pkg::POT_W-1:0];
      end
   end

   assign fire = ch_ok && !refr && (pot_sat > threshold_ff);

   always_comb begin
      if (!ch_ok || refr) begin
         rsp_pot_in = rest_level_ff;
      end else if (fire) begin
         rsp_pot_in = spike_level_ff;
      end else begin
         rsp_pot_in = pot_sat;
      end
      rsp_spike_in = fire;

      wr_in.vld      = b_valid_ff && ch_ok;
      wr_in.ch       = b_ch_ff;
      wr_in.st.mem   = rsp_pot_in;
      wr_in.st.since = fire ? '0 : d_sat;
   end

   // write history for the bypass; only the valid bits need a reset
   always_ff @(posedge clock) begin
      if (reset) begin
         wr1_ff.vld <= 1'b0;
         wr2_ff.vld <= 1'b0;
      end else if (adv) begin
         wr1_ff <= wr_in;
         wr2_ff <= wr1_ff;
      end
   end

   // ---------------- stage C: result register ----------------
   logic [lnb_pkg::CH_W-1:0]           rsp_ch_ff;
   logic signed [lnb_pkg::POT_W-1:0]   rsp_pot_ff;
   logic                               rsp_spike_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ch_ff    <= b_ch_ff;
         rsp_pot_ff   <= rsp_pot_in;
         rsp_spike_ff <= rsp_spike_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_spike_ff, rsp_pot_ff, rsp_ch_ff};

endmodule

`default_nettype wire

### src/lnb_checker.sv
// ---------------------------------------------------------------------------
// lnb_checker
// Port-level checks for the neuron bank, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module lnb_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic [lnb_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [lnb_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // no result comes out of reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // an empty result side never blocks the request side
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output");

   // with the sink ready while it passes stages A and B, a request beat comes out with its channel
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tvalid && (rsp_tdata[5:0] == $past(req_tdata[5:0], 3)))
      else $error("result missing or wrong channel");

endmodule

bind lif_neuron_bank_top lnb_checker u_lnb_checker (.*);

`default_nettype wire
